>>> hw/rtl/bfp_pkg.sv
// shared types and constants of the byte fifo packetizer
`timescale 1ns / 1ps
package bfp_pkg;

  localparam int DEF_FIFO_DEPTH   = 1024;
  localparam int DEF_PACKET_BYTES = 64;

  localparam int OPCODE_W = 2;
  localparam int BYTE_W   = 8;
  localparam int DROP_W   = 32;
  localparam int FILL_W   = 10;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH = 2'd0,
    OP_DONE = 2'd1,
    OP_OPEN = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_DONE,
    CMD_OPEN,
    CMD_NONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [BYTE_W-1:0] data;
    logic              line_end;
    logic              pump;
    logic              accepts;
  } cmd_t;

  typedef enum logic [1:0] {
    APP_DATA,
    APP_CR,
    APP_LF
  } app_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_PUMP,
    ST_STREAM,
    ST_STATUS
  } back_state_t;

endpackage

>>> hw/rtl/bfp_ifs.sv
// valid/ready channel interfaces of the byte fifo packetizer
`timescale 1ns / 1ps
interface bfp_in_if
  import bfp_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [BYTE_W-1:0]   byte_value;
  logic                add_line_end;
  logic                last_of_message;
  logic                endpoint_accepts;

  modport source (
    output valid, opcode, byte_value, add_line_end, last_of_message, endpoint_accepts,
    input  ready
  );
  modport sink (
    input  valid, opcode, byte_value, add_line_end, last_of_message, endpoint_accepts,
    output ready
  );
endinterface

interface bfp_out_if
  import bfp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] packet_byte;
  logic              packet_valid;
  logic              last_of_run;
  logic              packet_refused;
  logic [DROP_W-1:0] dropped_total;
  logic [FILL_W-1:0] fifo_fill;
  logic              transfer_busy;

  modport source (
    output valid, packet_byte, packet_valid, last_of_run, packet_refused,
           dropped_total, fifo_fill, transfer_busy,
    input  ready
  );
  modport sink (
    input  valid, packet_byte, packet_valid, last_of_run, packet_refused,
           dropped_total, fifo_fill, transfer_busy,
    output ready
  );
endinterface

>>> hw/rtl/bfp_front.sv
// front end: accepts items, classifies them into commands and queues them
`timescale 1ns / 1ps
module bfp_front
  import bfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  bfp_in_if.sink    in_ch,
  output logic      cmd_valid,
  output cmd_t      cmd,
  input  logic      cmd_pop
);

  cmd_t                cls;
  cmd_t                q_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_r, wr_nxt;
  logic [QUEUE_AW-1:0] rd_r, rd_nxt;
  logic [QUEUE_AW:0]   cnt_r, cnt_nxt;
  logic                push;

  // classify the incoming item
  always_comb begin
    cls.data     = in_ch.byte_value;
    cls.line_end = in_ch.add_line_end;
    cls.pump     = in_ch.last_of_message;
    cls.accepts  = in_ch.endpoint_accepts;
    case (in_ch.opcode)
      OP_PUSH: cls.kind = CMD_PUSH;
      OP_DONE: cls.kind = CMD_DONE;
      OP_OPEN: cls.kind = CMD_OPEN;
      default: cls.kind = CMD_NONE;
    endcase
  end

  assign in_ch.ready = (cnt_r != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != '0);
  assign cmd         = q_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = cmd_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= cls;
    end
  end

endmodule

>>> hw/rtl/bfp_back.sv
// back end: ring buffer, packet pump and result register
`timescale 1ns / 1ps
module bfp_back
  import bfp_pkg::*;
#(
  parameter int FIFO_DEPTH   = DEF_FIFO_DEPTH,
  parameter int PACKET_BYTES = DEF_PACKET_BYTES
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  bfp_out_if.source out_ch
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int NW = $clog2(PACKET_BYTES + 1);
  localparam int CW = (PW > NW) ? PW : NW;
  localparam logic [PW:0]   DEPTH_W = (PW+1)'(FIFO_DEPTH);
  localparam logic [CW-1:0] PKT_C   = CW'(PACKET_BYTES);

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  back_state_t       state_r, state_nxt;
  logic [PW-1:0]     wp_r, wp_nxt;
  logic [PW-1:0]     rp_r, rp_nxt;
  logic              busy_r, busy_nxt;
  logic [DROP_W-1:0] drop_r, drop_nxt;
  cmd_t              cmd_r, cmd_nxt;
  app_sel_t          app_r, app_nxt;
  logic              refused_r, refused_nxt;
  logic [NW-1:0]     cnt_r, cnt_nxt;
  logic [PW-1:0]     sfill_r, sfill_nxt;

  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] ob_r, ob_nxt;
  logic              opv_r, opv_nxt;
  logic              olast_r, olast_nxt;
  logic              oref_r, oref_nxt;
  logic [DROP_W-1:0] odrop_r, odrop_nxt;
  logic [FILL_W-1:0] ofill_r, ofill_nxt;
  logic              obusy_r, obusy_nxt;

  logic [BYTE_W-1:0] mem [FIFO_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;
  logic              mem_we;
  logic [BYTE_W-1:0] mem_wdata;
  logic [PW-1:0]     rd_addr;

  logic [PW:0]       fill_wrap;
  logic [PW-1:0]     fill_cur;
  logic [CW-1:0]     fill_c;
  logic [NW-1:0]     pkt_n;
  logic [PW:0]       rp_sum;
  logic [PW-1:0]     rp_adv;
  logic              app_last;
  logic              slot_free;
  logic              can_send;

  // ring occupancy and packet size
  always_comb begin
    fill_wrap = DEPTH_W - (PW+1)'(rp_r) + (PW+1)'(wp_r);
    fill_cur  = (wp_r >= rp_r) ? (wp_r - rp_r) : fill_wrap[PW-1:0];
    fill_c    = CW'(fill_cur);
    pkt_n     = NW'((fill_c > PKT_C) ? PKT_C : fill_c);
    rp_sum    = (PW+1)'(rp_r) + (PW+1)'(pkt_n);
    rp_adv    = (rp_sum >= DEPTH_W) ? PW'(rp_sum - DEPTH_W) : rp_sum[PW-1:0];
    app_last  = (app_r == APP_LF) || ((app_r == APP_DATA) && !cmd_r.line_end);
    slot_free = !ov_r || out_ch.ready;
    can_send  = !busy_r && (fill_cur != '0) && cmd_r.accepts;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_PUSH: state_nxt = ST_APPEND;
            CMD_DONE: state_nxt = ST_PUMP;
            default:  state_nxt = ST_STATUS;
          endcase
        end
      end
      ST_APPEND: begin
        if (app_last) begin
          state_nxt = cmd_r.pump ? ST_PUMP : ST_STATUS;
        end
      end
      ST_PUMP: begin
        state_nxt = can_send ? ST_STREAM : ST_STATUS;
      end
      ST_STREAM: begin
        if (slot_free && (cnt_r == '0)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_STATUS: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    busy_nxt    = busy_r;
    drop_nxt    = drop_r;
    cmd_nxt     = cmd_r;
    app_nxt     = app_r;
    refused_nxt = refused_r;
    cnt_nxt     = cnt_r;
    sfill_nxt   = sfill_r;
    cmd_pop     = 1'b0;
    mem_we      = 1'b0;
    rd_addr     = rp_r;
    ov_nxt      = ov_r && !out_ch.ready;
    ob_nxt      = ob_r;
    opv_nxt     = opv_r;
    olast_nxt   = olast_r;
    oref_nxt    = oref_r;
    odrop_nxt   = odrop_r;
    ofill_nxt   = ofill_r;
    obusy_nxt   = obusy_r;

    case (app_r)
      APP_DATA: mem_wdata = cmd_r.data;
      APP_CR:   mem_wdata = CHAR_CR;
      default:  mem_wdata = CHAR_LF;
    endcase

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop     = 1'b1;
          cmd_nxt     = cmd;
          app_nxt     = APP_DATA;
          refused_nxt = 1'b0;
          case (cmd.kind)
            CMD_DONE: busy_nxt = 1'b0;
            CMD_OPEN: begin
              wp_nxt   = '0;
              rp_nxt   = '0;
              busy_nxt = 1'b0;
              drop_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_APPEND: begin
        if (ptr_next(wp_r) == rp_r) begin
          drop_nxt = drop_r + 1'b1;
        end else begin
          mem_we = 1'b1;
          wp_nxt = ptr_next(wp_r);
        end
        case (app_r)
          APP_DATA: app_nxt = APP_CR;
          default:  app_nxt = APP_LF;
        endcase
      end
      ST_PUMP: begin
        if (!busy_r && (fill_cur != '0)) begin
          if (cmd_r.accepts) begin
            busy_nxt  = 1'b1;
            cnt_nxt   = pkt_n - 1'b1;
            sfill_nxt = fill_cur - PW'(pkt_n);
          end else begin
            rp_nxt      = rp_adv;
            drop_nxt    = drop_r + DROP_W'(pkt_n);
            refused_nxt = 1'b1;
          end
        end
      end
      ST_STREAM: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = rd_data_r;
          opv_nxt   = 1'b1;
          olast_nxt = (cnt_r == '0);
          oref_nxt  = 1'b0;
          odrop_nxt = drop_r;
          ofill_nxt = FILL_W'(sfill_r);
          obusy_nxt = busy_r;
          rp_nxt    = ptr_next(rp_r);
          rd_addr   = ptr_next(rp_r);
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      ST_STATUS: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = '0;
          opv_nxt   = 1'b0;
          olast_nxt = 1'b1;
          oref_nxt  = refused_r;
          odrop_nxt = drop_r;
          ofill_nxt = FILL_W'(fill_cur);
          obusy_nxt = busy_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      rp_r    <= '0;
      busy_r  <= 1'b0;
      drop_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      busy_r  <= busy_nxt;
      drop_r  <= drop_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    app_r     <= app_nxt;
    refused_r <= refused_nxt;
    cnt_r     <= cnt_nxt;
    sfill_r   <= sfill_nxt;
    ob_r      <= ob_nxt;
    opv_r     <= opv_nxt;
    olast_r   <= olast_nxt;
    oref_r    <= oref_nxt;
    odrop_r   <= odrop_nxt;
    ofill_r   <= ofill_nxt;
    obusy_r   <= obusy_nxt;
  end

  // ring storage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.packet_byte    = ob_r;
  assign out_ch.packet_valid   = opv_r;
  assign out_ch.last_of_run    = olast_r;
  assign out_ch.packet_refused = oref_r;
  assign out_ch.dropped_total  = odrop_r;
  assign out_ch.fifo_fill      = ofill_r;
  assign out_ch.transfer_busy  = obusy_r;

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r < PW'(FIFO_DEPTH - 1) || wp_r == PW'(FIFO_DEPTH - 1)) &&
    (rp_r < PW'(FIFO_DEPTH - 1) || rp_r == PW'(FIFO_DEPTH - 1)))
    else $error("ring pointer out of range");

  a_stream_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STREAM |-> busy_r)
    else $error("packet streaming without busy mark");

  a_pkt_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && opv_r |-> obusy_r)
    else $error("packet byte reported without transfer busy");

  a_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && oref_r |-> !opv_r && olast_r)
    else $error("refused result carries packet data");

  a_stream_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STREAM |-> cnt_r < NW'(PACKET_BYTES))
    else $error("packet byte count exceeds packet size");

endmodule

>>> hw/rtl/byte_fifo_packetizer_top.sv
// top level of the byte fifo packetizer
// flow: pop the command, append to the ring (the byte, or byte, CR and LF with line end),
// run the pump when due, register the result, then one packet byte per cycle unless output stalls
// the front queue takes new items while the back end works; the back end pops only when idle
// reset: synchronous active low, clears pointers, busy mark, drop count and queue; ring not cleared
`timescale 1ns / 1ps
module byte_fifo_packetizer_top
  import bfp_pkg::*;
#(
  parameter int FIFO_DEPTH   = DEF_FIFO_DEPTH,
  parameter int PACKET_BYTES = DEF_PACKET_BYTES
) (
  input  logic      clk,
  input  logic      rst_n,
  bfp_in_if.sink    in_ch,
  bfp_out_if.source out_ch
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  bfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  bfp_back #(
    .FIFO_DEPTH   (FIFO_DEPTH),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

endmodule
